### rtl/cst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the connection slot table.
// Used by cst_ctrl, cst_dp and connection_slot_table_unit; no dependencies.
package cst_pkg;

  localparam int unsigned POOL_ENTRIES = 16;
  localparam int unsigned IDX_W        = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

  localparam int unsigned HOST_W   = 64;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned KIND_W   = 4;

  localparam logic [TIME_W-1:0] IDLE_LIMIT_RST = 32'd60;

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_INSTALL = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_EVICT   = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLOSE       = 4'd0,
    KIND_HIT         = 4'd1,
    KIND_RESERVED    = 4'd2,
    KIND_BYPASS      = 4'd3,
    KIND_INSTALLED   = 4'd4,
    KIND_RELEASED    = 4'd5,
    KIND_REL_UNKNOWN = 4'd6,
    KIND_EVICTED     = 4'd7,
    KIND_EVICT_NONE  = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INVAL_CUR,
    OP_BUSY_CUR,
    OP_INVAL_OLD,
    OP_INSTALL,
    OP_RELEASE_CUR
  } slot_op_e;

  typedef enum logic [1:0] {
    HSEL_ZERO,
    HSEL_CUR,
    HSEL_REQ,
    HSEL_OLD
  } hsel_e;

  typedef enum logic [1:0] {
    SSEL_ZERO,
    SSEL_SCAN,
    SSEL_IDX,
    SSEL_OLD
  } ssel_e;

  typedef struct packed {
    logic     load_req;
    logic     scan_clr;
    logic     scan_inc;
    logic     old_track;
    slot_op_e op;
    logic     emit;
    kind_e    kind;
    hsel_e    hsel;
    ssel_e    ssel;
    logic     last;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    cur_valid;
    logic    cur_match;
    logic    cur_expired;
    logic    cur_hmatch;
    logic    scan_last;
    logic    old_found;
    logic    install_ok;
    logic    out_free;
  } sts_t;

endpackage

### rtl/cst_dp.sv
`timescale 1ns / 1ps
// Datapath of the connection slot table: request and limit registers, slot storage,
// scan pointer, oldest-slot tracker and result register. Depends on cst_pkg.
module cst_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cst_pkg::cmd_t                     cmd_i,
  output cst_pkg::sts_t                     sts_o,
  input  logic [1:0]                        action_i,
  input  logic [cst_pkg::HOST_W-1:0]        host_key_i,
  input  logic [cst_pkg::PORT_W-1:0]        port_i,
  input  logic [cst_pkg::HANDLE_W-1:0]      handle_i,
  input  logic [cst_pkg::SLOT_W-1:0]        slot_index_i,
  input  logic [cst_pkg::TIME_W-1:0]        now_seconds_i,
  input  logic                              cfg_we_i,
  input  logic [cst_pkg::TIME_W-1:0]        cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cst_pkg::KIND_W-1:0]        kind_o,
  output logic [cst_pkg::HANDLE_W-1:0]      out_handle_o,
  output logic [cst_pkg::SLOT_W-1:0]        out_slot_o,
  output logic                              last_o
);

  localparam int unsigned N = cst_pkg::POOL_ENTRIES;
  localparam int unsigned W = cst_pkg::IDX_W;

  cst_pkg::action_e                 req_action_q;
  logic [cst_pkg::HOST_W-1:0]       req_host_q;
  logic [cst_pkg::PORT_W-1:0]       req_port_q;
  logic [cst_pkg::HANDLE_W-1:0]     req_handle_q;
  logic [cst_pkg::SLOT_W-1:0]       req_idx_q;
  logic [cst_pkg::TIME_W-1:0]       req_now_q;
  logic [cst_pkg::TIME_W-1:0]       limit_q;

  logic [N-1:0]                     valid_q;
  logic [N-1:0]                     busy_q;
  logic [cst_pkg::HOST_W-1:0]       host_q   [N];
  logic [cst_pkg::PORT_W-1:0]       port_q   [N];
  logic [cst_pkg::HANDLE_W-1:0]     handle_q [N];
  logic [cst_pkg::TIME_W-1:0]       time_q   [N];

  logic [W-1:0]                     scan_q;
  logic                             old_found_q;
  logic [W-1:0]                     old_idx_q;
  logic [cst_pkg::TIME_W-1:0]       old_time_q;
  logic [cst_pkg::HANDLE_W-1:0]     old_handle_q;

  logic                             out_valid_q;
  logic [cst_pkg::KIND_W-1:0]       kind_q;
  logic [cst_pkg::HANDLE_W-1:0]     out_handle_q;
  logic [cst_pkg::SLOT_W-1:0]       out_slot_q;
  logic                             last_q;

  logic [cst_pkg::HOST_W-1:0]       cur_host;
  logic [cst_pkg::PORT_W-1:0]       cur_port;
  logic [cst_pkg::HANDLE_W-1:0]     cur_handle;
  logic [cst_pkg::TIME_W-1:0]       cur_time;
  logic [cst_pkg::TIME_W-1:0]       cur_idle;
  logic                             cur_valid;
  logic                             cur_busy;
  logic                             install_ok;
  logic [W-1:0]                     inst_addr;
  logic                             old_better;
  logic [cst_pkg::HANDLE_W-1:0]     handle_sel;
  logic [W-1:0]                     slot_sel;

  // Current slot under the scan pointer
  assign cur_host   = host_q[scan_q];
  assign cur_port   = port_q[scan_q];
  assign cur_handle = handle_q[scan_q];
  assign cur_time   = time_q[scan_q];
  assign cur_valid  = valid_q[scan_q];
  assign cur_busy   = busy_q[scan_q];
  assign cur_idle   = (req_now_q > cur_time) ? (req_now_q - cur_time) : '0;

  assign install_ok = (32'(req_idx_q) < N);
  assign inst_addr  = W'(req_idx_q);
  assign old_better = cur_valid && !cur_busy && (cur_time < old_time_q);

  always_comb begin
    sts_o.action      = req_action_q;
    sts_o.cur_valid   = cur_valid;
    sts_o.cur_match   = cur_valid && !cur_busy && (cur_port == req_port_q) &&
                        (cur_host == req_host_q);
    sts_o.cur_expired = (cur_idle > limit_q);
    sts_o.cur_hmatch  = cur_valid && (cur_handle == req_handle_q);
    sts_o.scan_last   = (scan_q == W'(N - 1));
    sts_o.old_found   = old_found_q;
    sts_o.install_ok  = install_ok;
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  // Request capture and idle limit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_action_q <= cst_pkg::action_e'(action_i);
      req_host_q   <= host_key_i;
      req_port_q   <= port_i;
      req_handle_q <= handle_i;
      req_idx_q    <= slot_index_i;
      req_now_q    <= now_seconds_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= cst_pkg::IDLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Scan pointer and oldest idle tracker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      old_found_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      scan_q      <= '0;
      old_found_q <= 1'b0;
    end else begin
      if (cmd_i.scan_inc) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.old_track && old_better) begin
        old_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      old_time_q <= req_now_q;
    end else if (cmd_i.old_track && old_better) begin
      old_time_q   <= cur_time;
      old_idx_q    <= scan_q;
      old_handle_q <= cur_handle;
    end
  end

  // Slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      busy_q  <= '0;
    end else begin
      case (cmd_i.op)
        cst_pkg::OP_INVAL_CUR: begin
          valid_q[scan_q] <= 1'b0;
          busy_q[scan_q]  <= 1'b0;
        end
        cst_pkg::OP_BUSY_CUR: begin
          busy_q[scan_q] <= 1'b1;
        end
        cst_pkg::OP_INVAL_OLD: begin
          valid_q[old_idx_q] <= 1'b0;
          busy_q[old_idx_q]  <= 1'b0;
        end
        cst_pkg::OP_INSTALL: begin
          if (install_ok) begin
            valid_q[inst_addr] <= 1'b1;
            busy_q[inst_addr]  <= 1'b1;
          end
        end
        cst_pkg::OP_RELEASE_CUR: begin
          busy_q[scan_q] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Slot payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == cst_pkg::OP_INSTALL && install_ok) begin
      host_q[inst_addr]   <= req_host_q;
      port_q[inst_addr]   <= req_port_q;
      handle_q[inst_addr] <= req_handle_q;
      time_q[inst_addr]   <= req_now_q;
    end else if (cmd_i.op == cst_pkg::OP_RELEASE_CUR) begin
      time_q[scan_q] <= req_now_q;
    end
  end

  // Result register
  always_comb begin
    case (cmd_i.hsel)
      cst_pkg::HSEL_CUR: handle_sel = cur_handle;
      cst_pkg::HSEL_REQ: handle_sel = req_handle_q;
      cst_pkg::HSEL_OLD: handle_sel = old_handle_q;
      default:           handle_sel = '0;
    endcase
    case (cmd_i.ssel)
      cst_pkg::SSEL_SCAN: slot_sel = scan_q;
      cst_pkg::SSEL_IDX:  slot_sel = inst_addr;
      cst_pkg::SSEL_OLD:  slot_sel = old_idx_q;
      default:            slot_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q       <= cmd_i.kind;
      out_handle_q <= handle_sel;
      out_slot_q   <= cst_pkg::SLOT_W'(slot_sel);
      last_q       <= cmd_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign out_handle_o = out_handle_q;
  assign out_slot_o   = out_slot_q;
  assign last_o       = last_q;

endmodule

### rtl/cst_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the connection slot table: walks the slot scans and issues
// datapath commands. Depends on cst_pkg.
module cst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cst_pkg::sts_t sts_i,
  output cst_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MATCH,
    ST_OLDEST,
    ST_RESOLVE,
    ST_RESERVE,
    ST_INSTALL,
    ST_FIND
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.op        = cst_pkg::OP_NONE;
    cmd_o.kind      = cst_pkg::KIND_CLOSE;
    cmd_o.hsel      = cst_pkg::HSEL_ZERO;
    cmd_o.ssel      = cst_pkg::SSEL_ZERO;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_stall_q) begin
          cmd_o.load_req = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        case (sts_i.action)
          cst_pkg::ACT_ACQUIRE: state_d = ST_MATCH;
          cst_pkg::ACT_INSTALL: state_d = ST_INSTALL;
          default:              state_d = ST_FIND;
        endcase
      end

      // First pass: idle host/port match; expired matches are closed on the way
      ST_MATCH: begin
        if (sts_i.cur_match) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.hsel = cst_pkg::HSEL_CUR;
            cmd_o.ssel = cst_pkg::SSEL_SCAN;
            if (sts_i.cur_expired) begin
              cmd_o.kind = cst_pkg::KIND_CLOSE;
              cmd_o.op   = cst_pkg::OP_INVAL_CUR;
              if (sts_i.scan_last) begin
                cmd_o.scan_clr = 1'b1;
                state_d        = ST_OLDEST;
              end else begin
                cmd_o.scan_inc = 1'b1;
              end
            end else begin
              cmd_o.kind = cst_pkg::KIND_HIT;
              cmd_o.op   = cst_pkg::OP_BUSY_CUR;
              cmd_o.last = 1'b1;
              state_d    = ST_IDLE;
            end
          end
        end else if (sts_i.scan_last) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_OLDEST;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end

      // Second pass: first empty slot, else track the oldest idle slot
      ST_OLDEST: begin
        if (!sts_i.cur_valid) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = cst_pkg::KIND_RESERVED;
            cmd_o.ssel = cst_pkg::SSEL_SCAN;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd_o.old_track = 1'b1;
          if (sts_i.scan_last) begin
            state_d = ST_RESOLVE;
          end else begin
            cmd_o.scan_inc = 1'b1;
          end
        end
      end

      ST_RESOLVE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.old_found) begin
            cmd_o.kind = cst_pkg::KIND_CLOSE;
            cmd_o.hsel = cst_pkg::HSEL_OLD;
            cmd_o.ssel = cst_pkg::SSEL_OLD;
            cmd_o.op   = cst_pkg::OP_INVAL_OLD;
            state_d    = ST_RESERVE;
          end else begin
            cmd_o.kind = cst_pkg::KIND_BYPASS;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end

      ST_RESERVE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = cst_pkg::KIND_RESERVED;
          cmd_o.ssel = cst_pkg::SSEL_OLD;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_INSTALL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.hsel = cst_pkg::HSEL_REQ;
          cmd_o.last = 1'b1;
          if (sts_i.install_ok) begin
            cmd_o.kind = cst_pkg::KIND_INSTALLED;
            cmd_o.ssel = cst_pkg::SSEL_IDX;
            cmd_o.op   = cst_pkg::OP_INSTALL;
          end else begin
            cmd_o.kind = cst_pkg::KIND_BYPASS;
          end
          state_d = ST_IDLE;
        end
      end

      // Handle search for release and evict; lowest matching slot wins
      ST_FIND: begin
        if (sts_i.cur_hmatch) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.hsel = cst_pkg::HSEL_REQ;
            cmd_o.ssel = cst_pkg::SSEL_SCAN;
            cmd_o.last = 1'b1;
            if (sts_i.action == cst_pkg::ACT_RELEASE) begin
              cmd_o.kind = cst_pkg::KIND_RELEASED;
              cmd_o.op   = cst_pkg::OP_RELEASE_CUR;
            end else begin
              cmd_o.kind = cst_pkg::KIND_EVICTED;
              cmd_o.op   = cst_pkg::OP_INVAL_CUR;
            end
            state_d = ST_IDLE;
          end
        end else if (sts_i.scan_last) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.hsel = cst_pkg::HSEL_REQ;
            cmd_o.last = 1'b1;
            cmd_o.kind = (sts_i.action == cst_pkg::ACT_RELEASE) ?
                         cst_pkg::KIND_REL_UNKNOWN : cst_pkg::KIND_EVICT_NONE;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_stall_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_stall_q <= (state_d != ST_IDLE);
    end
  end

  assign in_stall_o = in_stall_q;

endmodule

### rtl/connection_slot_table_unit.sv
`timescale 1ns / 1ps
// Top level of the connection slot table: sequencer plus datapath.
// Depends on cst_pkg, cst_ctrl and cst_dp.

// Pooled connection slot table with POOL_ENTRIES (16) slots. Each request beat
// is worked on alone: the slot store has a single read port, and the sequencer
// walks it one slot per cycle unless a step that wants to emit is held by a
// result stall. Release and evict end on the first slot whose handle matches,
// or on the last slot when none does. Acquire runs a match pass (stopping on a
// hit), then, on a miss, an empty/oldest pass that stops at the first empty
// slot, then reports the oldest idle slot (a close beat, then a reserve beat)
// or a bypass. Every result beat goes through one output register; a stall on
// the result side holds the sequencer at the step that wants to emit, and an
// expired match is invalidated in the same step that emits its close beat.
// The input side is stalled from the accepting edge until the last result beat
// of that request is loaded into the output register, so a new request can be
// taken while that last beat waits.
// The idle limit (reset 60 s) is written through cfg_we_i/cfg_wdata_i and must
// only change while no request is in flight.
module connection_slot_table_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [cst_pkg::TIME_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [cst_pkg::HOST_W-1:0]   host_key_i,
  input  logic [cst_pkg::PORT_W-1:0]   port_i,
  input  logic [cst_pkg::HANDLE_W-1:0] handle_i,
  input  logic [cst_pkg::SLOT_W-1:0]   slot_index_i,
  input  logic [cst_pkg::TIME_W-1:0]   now_seconds_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cst_pkg::KIND_W-1:0]   kind_o,
  output logic [cst_pkg::HANDLE_W-1:0] out_handle_o,
  output logic [cst_pkg::SLOT_W-1:0]   out_slot_o,
  output logic                         last_o
);

  cst_pkg::cmd_t cmd;
  cst_pkg::sts_t sts;

  // Sequencer: one scan step per cycle unless a step waits to emit, emits only into a free output register
  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Slot store, scan pointer, oldest tracker and result register
  cst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .host_key_i    (host_key_i),
    .port_i        (port_i),
    .handle_i      (handle_i),
    .slot_index_i  (slot_index_i),
    .now_seconds_i (now_seconds_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_handle_o  (out_handle_o),
    .out_slot_o    (out_slot_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  // A result beat is loaded only when the output register is empty or draining
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a held beat");

  // An accepted request closes the input side on the next cycle
  a_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input side open while a request is in flight");

  // The final beat of a request reopens the input side
  a_last_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last) |=> !in_stall_o)
    else $error("input side still stalled after the final beat");

  // No request is taken while the sequencer is loading a result
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !cmd.load_req)
    else $error("request loaded while emitting");
`endif

endmodule
